@@ hdl/ecgbp_pkg.sv @@
package ecgbp_pkg;

    // Data format
    localparam int ADC_BITS         = 12;
    localparam int SAMPLE_FRAC_BITS = 16;
    localparam int COEF_FRAC_BITS   = 44;

    localparam int TIME_W   = 32;
    localparam int SAMPLE_W = 32;
    localparam int RAW_W    = 22;
    localparam int COEF_W   = 64;
    localparam int HALF_W   = COEF_W / 2;
    localparam int PROD_W   = HALF_W + 1 + SAMPLE_W;
    localparam int ACC_W    = COEF_W + SAMPLE_W + 4;

    // Millivolt scaling: 3.3 V reference, gain 100, V -> mV gives 33 / full scale
    localparam int MV_SCALE  = 33;
    localparam int MV_BITS   = $clog2(MV_SCALE);
    localparam int FS_CODE   = (1 << ADC_BITS) - 1;
    localparam int HALF_FS   = FS_CODE / 2;
    localparam int QUOT_W    = SAMPLE_FRAC_BITS + MV_BITS;
    localparam int DVD_W     = ADC_BITS + QUOT_W;
    // each fold by 2^ADC_BITS - 1 strips ADC_BITS bits off the remainder
    localparam int DIV_STEPS = (DVD_W + ADC_BITS - 1) / ADC_BITS + 1;

    // Filter structure: fourth order direct form I
    localparam int HIST_DEPTH = 4;
    localparam int HIST_IDX_W = $clog2(HIST_DEPTH);
    localparam int N_TERMS    = 2 * HIST_DEPTH + 1;
    localparam int TERM_W     = $clog2(N_TERMS);
    localparam int MAC_STEPS  = 2 * N_TERMS;
    localparam int CNT_MAX    = (DIV_STEPS > MAC_STEPS) ? DIV_STEPS : MAC_STEPS;
    localparam int CNT_W      = $clog2(CNT_MAX);

    localparam logic [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // Coefficient design constants
    localparam int          WF         = 56;
    localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
    localparam int          RATE_HZ    = 500;
    localparam int          PI_SHIFT_F = 16;    // Q60 -> Q56
    localparam int          LP_TWO_F0  = 80;    // 2 * 40 Hz
    localparam int          HP_TWO_F0  = 1;     // 2 * 0.5 Hz
    localparam int          AL1_NUM    = 26131; // 2.6131
    localparam int          AL2_NUM    = 34142; // 3.4142
    localparam int          AL_DEN     = 10000;

    typedef logic [63:0] t_u64;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic [N_TERMS-1:0][COEF_W-1:0] t_coef_set;
    typedef logic [HIST_DEPTH-1:0][SAMPLE_W-1:0] t_hist;

    typedef enum logic [0:0] {
        STAGE_LP,
        STAGE_HP
    } t_stage;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MAC,
        S_DRAIN,
        S_FIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              load_in;
        logic              div_step;
        logic              acc_clear;
        logic              mul_en;
        logic [TERM_W-1:0] term;
        logic              half;
        logic              acc_en;
        logic              finish;
        logic              load_out;
        t_stage            stage;
    } t_cmd;

    // (a * b) / c over a 128-bit product, restoring, truncating
    function automatic t_u64 muldiv(input t_u64 a, input t_u64 b, input t_u64 c);
        logic [127:0] w;
        t_u64         r;
        t_u64         q;
        logic         top;
        int           i;
        w = {64'd0, a} * {64'd0, b};
        r = '0;
        q = '0;
        if (c == 64'd0) begin
            return '1;
        end
        for (i = 127; i >= 0; i--) begin
            top = r[63];
            r   = {r[62:0], w[i]};
            q   = {q[62:0], 1'b0};
            if (top || (r >= c)) begin
                r    = r - c;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_u64 mulq(input t_u64 a, input t_u64 b);
        return muldiv(a, b, 64'd1 << WF);
    endfunction

    // num / d to COEF_FRAC_BITS, rounded half away from zero
    function automatic t_coef quant(input t_u64 num, input t_u64 d);
        logic neg;
        t_u64 mag;
        t_u64 q;
        neg = num[63];
        mag = neg ? (64'd0 - num) : num;
        q   = muldiv(mag, 64'd1 << (COEF_FRAC_BITS + 1), d);
        q   = (q + 64'd1) >> 1;
        return neg ? t_coef'(64'd0 - q) : t_coef'(q);
    endfunction

    // Bilinear Butterworth section. Order: b0..b4, then -a1..-a4.
    function automatic t_coef_set design_coefs(input t_u64 beta, input logic hp);
        t_u64      wone;
        t_u64      b2, b3, b4;
        t_u64      al1, al2, t1, t2, t3, d;
        t_u64      na [HIST_DEPTH];
        t_u64      nb [HIST_DEPTH+1];
        t_coef_set c;
        int        i;
        wone = 64'd1 << WF;
        b2   = mulq(beta, beta);
        b3   = mulq(b2, beta);
        b4   = mulq(b3, beta);
        al1  = muldiv(64'(AL1_NUM), wone, 64'(AL_DEN));
        al2  = muldiv(64'(AL2_NUM), wone, 64'(AL_DEN));
        t3   = mulq(al1, b3);
        t2   = mulq(al2, b2);
        t1   = mulq(al1, beta);
        d    = b4 + 64'd2 * t3 + 64'd4 * t2 + 64'd8 * t1 + 64'd16 * wone;
        na[0] = 64'd4 * b4 + 64'd4 * t3 - 64'd16 * t1 - 64'd64 * wone;
        na[1] = 64'd6 * b4 - 64'd8 * t2 + 64'd96 * wone;
        na[2] = 64'd4 * b4 - 64'd4 * t3 + 64'd16 * t1 - 64'd64 * wone;
        na[3] = b4 - 64'd2 * t3 + 64'd4 * t2 - 64'd8 * t1 + 64'd16 * wone;
        if (hp) begin
            nb[0] = 64'd16 * wone;
            nb[1] = 64'd0 - 64'd64 * wone;
            nb[2] = 64'd96 * wone;
            nb[3] = 64'd0 - 64'd64 * wone;
            nb[4] = 64'd16 * wone;
        end else begin
            nb[0] = b4;
            nb[1] = 64'd4 * b4;
            nb[2] = 64'd6 * b4;
            nb[3] = 64'd4 * b4;
            nb[4] = b4;
        end
        for (i = 0; i <= HIST_DEPTH; i++) begin
            c[i] = quant(nb[i], d);
        end
        for (i = 0; i < HIST_DEPTH; i++) begin
            c[HIST_DEPTH + 1 + i] = -quant(na[i], d);
        end
        return c;
    endfunction

    localparam t_u64 BETA_LP = muldiv(PI_Q60, 64'(LP_TWO_F0), 64'(RATE_HZ * PI_SHIFT_F));
    localparam t_u64 BETA_HP = muldiv(PI_Q60, 64'(HP_TWO_F0), 64'(RATE_HZ * PI_SHIFT_F));
    localparam t_coef_set LP_COEF = design_coefs(BETA_LP, 1'b0);
    localparam t_coef_set HP_COEF = design_coefs(BETA_HP, 1'b1);

endpackage

@@ hdl/ecgbp_ctrl.sv @@
module ecgbp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output ecgbp_pkg::t_cmd o_cmd
);
    import ecgbp_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_stage           r_stage, n_stage;
    logic             r_out_valid, n_out_valid;
    logic             w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_stage     <= STAGE_LP;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_stage     <= n_stage;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_stage     = r_stage;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DIV;
                    n_cnt   = '0;
                end
            end
            S_DIV: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_MAC;
                    n_cnt   = '0;
                    n_stage = STAGE_LP;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_MAC: begin
                if (r_cnt == CNT_W'(MAC_STEPS - 1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (r_stage == STAGE_LP) begin
                    n_state = S_MAC;
                    n_cnt   = '0;
                    n_stage = STAGE_HP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd       = '0;
        o_cmd.stage = r_stage;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load_in   = i_in_valid;
                o_cmd.acc_clear = i_in_valid;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_MAC: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.term   = TERM_W'(r_cnt >> 1);
                o_cmd.half   = r_cnt[0];
                o_cmd.acc_en = (r_cnt != '0);
            end
            S_DRAIN: begin
                o_cmd.acc_en = 1'b1;
            end
            S_FIN: begin
                o_cmd.finish    = 1'b1;
                o_cmd.acc_clear = 1'b1;
            end
            S_DONE: begin
                o_cmd.load_out = w_out_free;
            end
            default: begin
                o_cmd.stage = r_stage;
            end
        endcase
    end

    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DIV))
        else $error("accepted sample did not start scaling");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before transfer");

    a_mac_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_cnt < CNT_W'(MAC_STEPS)))
        else $error("tap counter out of range");

    a_hp_after_lp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_stage == STAGE_LP) |=>
            (r_state == S_MAC && r_stage == STAGE_HP && r_cnt == '0))
        else $error("high-pass stage did not follow low-pass");

endmodule

@@ hdl/ecgbp_dpath.sv @@
module ecgbp_dpath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  ecgbp_pkg::t_cmd                       i_cmd,
    input  logic [ecgbp_pkg::ADC_BITS-1:0]        i_adc_code,
    input  logic [ecgbp_pkg::TIME_W-1:0]          i_time_ms,
    output logic [ecgbp_pkg::TIME_W-1:0]          o_time_ms_out,
    output logic [ecgbp_pkg::RAW_W-1:0]           o_raw_mv,
    output logic signed [ecgbp_pkg::SAMPLE_W-1:0] o_filtered_mv,
    output logic                                  o_saturated
);
    import ecgbp_pkg::*;

    // scaling divider: one fold by 2^ADC_BITS - 1 per cycle
    logic [DVD_W-1:0]     w_dvd;
    logic [DVD_W-1:0]     w_rem_p1;
    logic [QUOT_W-1:0]    w_fold;
    logic [DVD_W-1:0]     w_rem_nx;
    logic [DVD_W-1:0]     r_rem;
    logic [QUOT_W-1:0]    r_quot;
    logic [TIME_W-1:0]    r_time;
    logic [SAMPLE_W-1:0]  w_raw32;

    // MAC
    t_hist                     r_lp_xh, r_lp_yh, r_hp_xh, r_hp_yh;
    t_hist                     w_xh, w_yh;
    logic [SAMPLE_W-1:0]       w_stage_in;
    logic [SAMPLE_W-1:0]       w_x;
    logic [TERM_W-1:0]         w_term_m1, w_term_my;
    logic [COEF_W-1:0]         w_coef;
    logic signed [HALF_W:0]    w_op_a;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_prod_hi;
    logic signed [ACC_W-1:0]   w_prod_ext;
    logic signed [ACC_W-1:0]   w_addend;
    logic signed [ACC_W-1:0]   r_acc;

    // round and clip
    logic [ACC_W-COEF_FRAC_BITS-SAMPLE_W:0] w_top;
    logic                                   w_fit;
    logic [SAMPLE_W-1:0]                    w_y;
    logic [SAMPLE_W-1:0]                    r_stage_y;
    logic                                   r_sat;

    assign w_dvd   = ((DVD_W'(i_adc_code) * DVD_W'(MV_SCALE)) << SAMPLE_FRAC_BITS)
                     + DVD_W'(HALF_FS);
    // rem + 1 = fold * 2^ADC_BITS + low, so rem = fold * FS_CODE + (fold + low - 1);
    // settles once rem < FS_CODE
    assign w_rem_p1 = r_rem + DVD_W'(1);
    assign w_fold   = w_rem_p1[DVD_W-1:ADC_BITS];
    assign w_rem_nx = DVD_W'(w_fold) + DVD_W'(w_rem_p1[ADC_BITS-1:0]) - DVD_W'(1);
    assign w_raw32  = SAMPLE_W'(r_quot);

    assign w_stage_in = (i_cmd.stage == STAGE_LP) ? w_raw32 : r_stage_y;
    assign w_xh       = (i_cmd.stage == STAGE_LP) ? r_lp_xh : r_hp_xh;
    assign w_yh       = (i_cmd.stage == STAGE_LP) ? r_lp_yh : r_hp_yh;
    assign w_coef     = (i_cmd.stage == STAGE_LP) ? LP_COEF[i_cmd.term]
                                                  : HP_COEF[i_cmd.term];
    assign w_term_m1  = i_cmd.term - TERM_W'(1);
    assign w_term_my  = i_cmd.term - TERM_W'(HIST_DEPTH + 1);

    // term 0: new input, then input history, then output history
    always_comb begin
        priority if (i_cmd.term == '0) begin
            w_x = w_stage_in;
        end else if (i_cmd.term <= TERM_W'(HIST_DEPTH)) begin
            w_x = w_xh[w_term_m1[HIST_IDX_W-1:0]];
        end else begin
            w_x = w_yh[w_term_my[HIST_IDX_W-1:0]];
        end
    end

    // 64-bit coefficient as two halves: unsigned low, signed high
    assign w_op_a = i_cmd.half ? {w_coef[COEF_W-1], w_coef[COEF_W-1:HALF_W]}
                               : {1'b0, w_coef[HALF_W-1:0]};
    assign w_prod = w_op_a * $signed(w_x);

    assign w_prod_ext = ACC_W'(r_prod);
    assign w_addend   = r_prod_hi ? (w_prod_ext <<< HALF_W) : w_prod_ext;

    assign w_top = r_acc[ACC_W-1:COEF_FRAC_BITS+SAMPLE_W-1];
    assign w_fit = (&w_top) | ~(|w_top);
    assign w_y   = w_fit ? r_acc[COEF_FRAC_BITS+SAMPLE_W-1:COEF_FRAC_BITS]
                         : (r_acc[ACC_W-1] ? SAT_MIN : SAT_MAX);

    // filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp_xh <= '0;
            r_lp_yh <= '0;
            r_hp_xh <= '0;
            r_hp_yh <= '0;
        end else if (i_cmd.finish) begin
            if (i_cmd.stage == STAGE_LP) begin
                r_lp_xh <= {r_lp_xh[HIST_DEPTH-2:0], w_stage_in};
                r_lp_yh <= {r_lp_yh[HIST_DEPTH-2:0], w_y};
            end else begin
                r_hp_xh <= {r_hp_xh[HIST_DEPTH-2:0], w_stage_in};
                r_hp_yh <= {r_hp_yh[HIST_DEPTH-2:0], w_y};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_rem  <= w_dvd;
            r_quot <= '0;
            r_time <= i_time_ms;
            r_sat  <= 1'b0;
        end else if (i_cmd.div_step) begin
            r_rem  <= w_rem_nx;
            r_quot <= r_quot + w_fold;
        end else if (i_cmd.finish) begin
            r_sat <= r_sat | ~w_fit;
        end

        if (i_cmd.mul_en) begin
            r_prod    <= w_prod;
            r_prod_hi <= i_cmd.half;
        end

        if (i_cmd.acc_clear) begin
            r_acc <= ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
        end else if (i_cmd.acc_en) begin
            r_acc <= r_acc + w_addend;
        end

        if (i_cmd.finish) begin
            r_stage_y <= w_y;
        end

        if (i_cmd.load_out) begin
            o_time_ms_out <= r_time;
            o_raw_mv      <= w_raw32[RAW_W-1:0];
            o_filtered_mv <= r_stage_y;
            o_saturated   <= r_sat;
        end
    end

endmodule

@@ hdl/ecg_bandpass_iir_cascade.sv @@
// ECG band-pass filter: 40 Hz Butterworth low-pass, then 0.5 Hz Butterworth
// high-pass, both fourth order direct form I, coefficients fixed at build.
//
// Input channel (i_in_valid / o_in_ready): one converter code and its
// millisecond timestamp per transfer. Output channel (o_out_valid /
// i_out_ready): timestamp, scaled input in mV (Q.16), filtered mV (Q.16,
// signed, clipped to 32 bits) and a flag set when either stage clipped.
//
// One sample at a time. An accepted sample goes through the scaling divider
// and then both filter stages into the output register, and the next sample
// is taken in the cycle after that. The processing time is set by the
// millivolt scaling divider (each step folding 12 bits of the dividend by
// 2^12 - 1) and by the single shared 33x32 multiplier, which takes each tap
// as a low and a high coefficient half, 9 taps per stage, plus a drain and
// a round/clip step per stage.
//
// The output register holds a finished result; a new sample is accepted
// while it waits. If the receiver still stalls when the next result is
// done, the block holds that result internally until the register frees.
// Synchronous reset clears all filter histories and empties the output.
module ecg_bandpass_iir_cascade (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [ecgbp_pkg::ADC_BITS-1:0]        i_adc_code,
    input  logic [ecgbp_pkg::TIME_W-1:0]          i_time_ms,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [ecgbp_pkg::TIME_W-1:0]          o_time_ms_out,
    output logic [ecgbp_pkg::RAW_W-1:0]           o_raw_mv,
    output logic signed [ecgbp_pkg::SAMPLE_W-1:0] o_filtered_mv,
    output logic                                  o_saturated
);
    import ecgbp_pkg::*;

    // command bundle from sequencer to datapath
    t_cmd w_cmd;

    ecgbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    // scaling divider, shared MAC, round/clip, histories, output register
    ecgbp_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_adc_code    (i_adc_code),
        .i_time_ms     (i_time_ms),
        .o_time_ms_out (o_time_ms_out),
        .o_raw_mv      (o_raw_mv),
        .o_filtered_mv (o_filtered_mv),
        .o_saturated   (o_saturated)
    );

endmodule

@@ tb/tb_ecg_bandpass_iir_cascade.sv @@
module tb_ecg_bandpass_iir_cascade;
    timeunit 1ns;
    timeprecision 1ps;

    import ecgbp_pkg::*;

    // Cycles with no transfer on either channel before the run is abandoned.
    // Random sender gaps and receiver stalls lengthen the time per sample.
    localparam int HANG_LIMIT   = 4000;
    // Quiet cycles after the last result, to catch anything extra.
    localparam int TAIL_CYCLES  = 150;
    localparam int ITEMS_PER_PH = 175;
    localparam int MAX_PRINTS   = 40;

    // Shapes of the random sample stream
    typedef enum int {
        WAVE_NOISE,
        WAVE_HOLD,
        WAVE_RAMP,
        WAVE_SPIKES
    } t_wave;

    typedef struct {
        logic [TIME_W-1:0]          ts;
        logic [RAW_W-1:0]           raw;
        logic signed [SAMPLE_W-1:0] filt;
        logic                       clip;
    } t_ecg_result;

    // Bit-true band-pass predictor plus the queue of results still owed.
    class bandpass_scoreboard;
        longint      num_coef [2][5];   // b0..b4
        longint      den_coef [2][4];   // a1..a4
        int          x_hist   [2][4];   // newest at index 0
        int          y_hist   [2][4];
        bit          step_clipped;
        t_ecg_result owed_results [$];
        int          mismatches;
        int          printed;

        function new();
            derive_section(STAGE_LP, mul_div(64'h3243F6A8885A308D, 64'd80, 64'd8000));
            derive_section(STAGE_HP, mul_div(64'h3243F6A8885A308D, 64'd1, 64'd8000));
            foreach (x_hist[s, i]) begin
                x_hist[s][i] = 0;
                y_hist[s][i] = 0;
            end
            mismatches = 0;
            printed    = 0;
        endfunction

        // (a*b)/c over the full 128-bit product, truncated
        function logic [63:0] mul_div(logic [63:0] a, logic [63:0] b, logic [63:0] c);
            logic [127:0] prod;
            prod = {64'd0, a} * {64'd0, b};
            return 64'(prod / {64'd0, c});
        endfunction

        // num/den in Q.COEF_FRAC_BITS, half away from zero; num is two's complement
        function longint quantize(logic [63:0] num, logic [63:0] den);
            logic        neg;
            logic [63:0] mag;
            logic [63:0] q;
            neg = num[63];
            mag = neg ? -num : num;
            q   = mul_div(mag, 64'd1 << (COEF_FRAC_BITS + 1), den);
            q   = (q + 64'd1) >> 1;
            return neg ? longint'(-q) : longint'(q);
        endfunction

        // Bilinear Butterworth, prototype 1, 2.6131, 3.4142, 2.6131, 1; Q56 math
        function void derive_section(t_stage sec, logic [63:0] beta);
            logic [63:0] one, b2, b3, b4, al1, al2, t1, t2, t3, den;
            logic [63:0] na [4];
            logic [63:0] nb [5];
            one = 64'd1 << 56;
            b2  = mul_div(beta, beta, one);
            b3  = mul_div(b2, beta, one);
            b4  = mul_div(b3, beta, one);
            al1 = mul_div(64'd26131, one, 64'd10000);
            al2 = mul_div(64'd34142, one, 64'd10000);
            t3  = mul_div(al1, b3, one);
            t2  = mul_div(al2, b2, one);
            t1  = mul_div(al1, beta, one);
            den = b4 + 64'd2 * t3 + 64'd4 * t2 + 64'd8 * t1 + 64'd16 * one;
            na[0] = 64'd4 * b4 + 64'd4 * t3 - 64'd16 * t1 - 64'd64 * one;
            na[1] = 64'd6 * b4 - 64'd8 * t2 + 64'd96 * one;
            na[2] = 64'd4 * b4 - 64'd4 * t3 + 64'd16 * t1 - 64'd64 * one;
            na[3] = b4 - 64'd2 * t3 + 64'd4 * t2 - 64'd8 * t1 + 64'd16 * one;
            if (sec == STAGE_HP) begin
                nb[0] = 64'd16 * one;
                nb[1] = -(64'd64 * one);
                nb[2] = 64'd96 * one;
                nb[3] = -(64'd64 * one);
                nb[4] = 64'd16 * one;
            end else begin
                nb[0] = b4;
                nb[1] = 64'd4 * b4;
                nb[2] = 64'd6 * b4;
                nb[3] = 64'd4 * b4;
                nb[4] = b4;
            end
            for (int i = 0; i < 5; i++) num_coef[sec][i] = quantize(nb[i], den);
            for (int i = 0; i < 4; i++) den_coef[sec][i] = quantize(na[i], den);
        endfunction

        // One direct form I step, exact accumulate, round, clip to 32 bits
        function int filter_section(t_stage sec, int x);
            logic signed [127:0] acc, full, cw, vw;
            int                  y;
            acc = 128'sd1 <<< (COEF_FRAC_BITS - 1);
            cw  = num_coef[sec][0];
            vw  = x;
            acc = acc + cw * vw;
            for (int i = 0; i < 4; i++) begin
                cw  = num_coef[sec][i+1];
                vw  = x_hist[sec][i];
                acc = acc + cw * vw;
                cw  = den_coef[sec][i];
                vw  = y_hist[sec][i];
                acc = acc - cw * vw;
            end
            full = acc >>> COEF_FRAC_BITS;
            if (full > 128'sd2147483647) begin
                y = 32'h7FFF_FFFF;
                step_clipped = 1'b1;
            end else if (full < -128'sd2147483648) begin
                y = 32'h8000_0000;
                step_clipped = 1'b1;
            end else begin
                y = int'(full[31:0]);
            end
            for (int i = 3; i > 0; i--) begin
                x_hist[sec][i] = x_hist[sec][i-1];
                y_hist[sec][i] = y_hist[sec][i-1];
            end
            x_hist[sec][0] = x;
            y_hist[sec][0] = y;
            return y;
        endfunction

        // Accepted sample: advance the filter and queue what it must produce
        function void take_sample(logic [ADC_BITS-1:0] code, logic [TIME_W-1:0] ts);
            logic [63:0] scaled;
            logic [63:0] fs_code;
            int          lp_out;
            t_ecg_result r;
            fs_code      = (64'd1 << ADC_BITS) - 64'd1;
            scaled       = ((64'(code) * 64'd33) << SAMPLE_FRAC_BITS) + fs_code / 64'd2;
            scaled       = scaled / fs_code;
            step_clipped = 1'b0;
            lp_out       = filter_section(STAGE_LP, int'(scaled[31:0]));
            r.filt       = filter_section(STAGE_HP, lp_out);
            r.ts         = ts;
            r.raw        = scaled[RAW_W-1:0];
            r.clip       = step_clipped;
            owed_results.push_back(r);
        endfunction

        function int outstanding();
            return owed_results.size();
        endfunction

        task report(string field, logic [63:0] got, logic [63:0] want);
            mismatches++;
            if (printed < MAX_PRINTS) begin
                printed++;
                $display("%t mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
            end
        endtask

        task check_output(logic [TIME_W-1:0] ts, logic [RAW_W-1:0] raw,
                          logic signed [SAMPLE_W-1:0] filt, logic clip);
            t_ecg_result w;
            if (owed_results.size() == 0) begin
                report("unexpected result transfer", {32'd0, ts}, 64'd0);
            end else begin
                w = owed_results.pop_front();
                if (ts !== w.ts)     report("time_ms_out", 64'(ts), 64'(w.ts));
                if (raw !== w.raw)   report("raw_mv", 64'(raw), 64'(w.raw));
                if (filt !== w.filt) report("filtered_mv", 64'(filt), 64'(w.filt));
                if (clip !== w.clip) report("saturated", 64'(clip), 64'(w.clip));
            end
        endtask
    endclass

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_ready;
    logic [ADC_BITS-1:0]        i_adc_code  = '0;
    logic [TIME_W-1:0]          i_time_ms   = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [TIME_W-1:0]          o_time_ms_out;
    logic [RAW_W-1:0]           o_raw_mv;
    logic signed [SAMPLE_W-1:0] o_filtered_mv;
    logic                       o_saturated;

    bandpass_scoreboard sb = new();

    // Idle percentages of the current phase, per cycle
    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int quiet_cycles    = 0;

    ecg_bandpass_iir_cascade dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_adc_code    (i_adc_code),
        .i_time_ms     (i_time_ms),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_time_ms_out (o_time_ms_out),
        .o_raw_mv      (o_raw_mv),
        .o_filtered_mv (o_filtered_mv),
        .o_saturated   (o_saturated)
    );

    always #5 i_clk = ~i_clk;

    // Result side: check on every transfer, then pick ready for the next cycle.
    // Values read here are the ones in place before this edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            sb.check_output(o_time_ms_out, o_raw_mv, o_filtered_mv, o_saturated);
        end
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Hang detector: any transfer on either channel restarts the count
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid === 1'b1 && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", HANG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Sender gaps come before the item, so valid is only ever raised after a
    // gap with valid low, or kept high straight into the next transfer.
    task automatic send_sample(logic [ADC_BITS-1:0] code, logic [TIME_W-1:0] ts);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_adc_code <= code;
        i_time_ms  <= ts;
        do @(posedge i_clk); while (!o_in_ready);
        sb.take_sample(code, ts);
    endtask

    // Hold the input off until every owed result has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() > 0);
    endtask

    initial begin
        logic [ADC_BITS-1:0] fixed_codes [20];
        logic [TIME_W-1:0]   fixed_times [7];
        t_wave               wave;
        int                  seg_left;
        int                  level;
        int                  slope;
        int                  code;
        logic [TIME_W-1:0]   stamp;
        int                  idle_set [4];
        int                  stall_set [4];

        // Directed: zero, full-scale step and hold, hard toggling between the
        // extremes, then codes around mid scale, next to the ends and at thirds.
        fixed_codes = '{12'd0, 12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
                        12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0,
                        12'd2048, 12'd2047, 12'd1, 12'd4094, 12'd1365, 12'd2730};
        fixed_times = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
        idle_set    = '{0, 63, 0, 11};
        stall_set   = '{0, 0, 63, 11};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (fixed_codes[n]) begin
            send_sample(fixed_codes[n], fixed_times[n % 7]);
        end
        wait_drained();

        // Random part: segments of noise, flat levels, ramps and QRS-like
        // spikes on a baseline; timestamps mostly step by a few ms, with
        // the odd jump anywhere in the 32-bit range.
        stamp    = $urandom;
        seg_left = 0;
        level    = 0;
        slope    = 1;
        wave     = WAVE_NOISE;
        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct = idle_set[ph];
            stall_pct       = stall_set[ph];
            for (int n = 0; n < ITEMS_PER_PH; n++) begin
                if (seg_left == 0) begin
                    wave     = t_wave'($urandom_range(3));
                    seg_left = $urandom_range(40, 8);
                    level    = $urandom_range(4095);
                    slope    = $urandom_range(400, 1);
                    if ($urandom_range(1)) slope = -slope;
                end
                seg_left--;
                case (wave)
                    WAVE_NOISE: begin
                        code = $urandom_range(4095);
                    end
                    WAVE_HOLD: begin
                        code = level + $urandom_range(8) - 4;
                    end
                    WAVE_RAMP: begin
                        level = level + slope;
                        if (level > 4095 || level < 0) slope = -slope;
                        code = level;
                    end
                    default: begin
                        code = ($urandom_range(9) == 0) ? 4095 - $urandom_range(20)
                                                         : level / 4;
                    end
                endcase
                if (code > 4095) code = 4095;
                if (code < 0) code = 0;
                stamp = ($urandom_range(49) == 0) ? $urandom : stamp + $urandom_range(4, 1);
                send_sample(ADC_BITS'(code), stamp);
            end
            // Pause between phases until the output side has caught up
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/ecgbp_pkg.sv
hdl/ecgbp_ctrl.sv
hdl/ecgbp_dpath.sv
hdl/ecg_bandpass_iir_cascade.sv
tb/tb_ecg_bandpass_iir_cascade.sv
